// ----- rtl/pte_pkg.sv -----
// Constants and types shared by the peer table with expiry.
package pte_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned OUT_CNT_MAX = 31;

  // Field widths
  localparam int unsigned KEY_W = 64;
  localparam int unsigned GRP_W = 32;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned TTL_W = 16;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned MS_W = 10;
  localparam int unsigned TTL_MS_W = TTL_W + MS_W;
  localparam logic [MS_W-1:0] MS_PER_SECOND = MS_W'(1000);

  // Action codes
  localparam logic [1:0] ACT_ANNOUNCE = 2'd0;
  localparam logic [1:0] ACT_EXPIRE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic CFG_OWN_KEY = 1'b0;
  localparam logic CFG_GROUP_KEY = 1'b1;

  // Status codes
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One stored entry payload
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] expiry;
  } entry_t;

endpackage

// ----- rtl/peer_table_with_expiry.sv -----
// Peer table with sequence filtering and time-to-live expiry (top level).
//
// Each item is a walk over the entry memory, which has one synchronous
// read port; every entry read passes ST_RD (address), then ST_CMP
// (compare). An announce passes ST_CALC, then reads the entries up to and
// including a key match, or all of them for an unknown peer, and passes
// ST_WRITE when it writes an entry. An announce dropped by key or group,
// a clear or an unused action goes straight to ST_FINISH; an expire tick
// reads every entry. busy is high from the accepting edge until the
// result beat; done_o marks the one cycle in which status_o and
// active_count_o are valid, and that beat cannot be held off. start is
// taken whenever busy is low. No clearing pass is needed after reset.
module peer_table_with_expiry import pte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [KEY_W-1:0]     cfg_wdata_i,
  // Command
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action_i,
  input  logic [KEY_W-1:0]     peer_key_i,
  input  logic [GRP_W-1:0]     msg_group_i,
  input  logic [SEQ_W-1:0]     seq_i,
  input  logic                 announce_active_i,
  input  logic [TTL_W-1:0]     ttl_seconds_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  // Result
  output logic                 done_o,
  output logic                 status_o,
  output logic [OUT_CNT_W-1:0] active_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_CMP,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [KEY_W-1:0] own_key_q;
  logic [GRP_W-1:0] group_key_q;

  // Latched command
  logic [1:0]          action_q;
  logic [KEY_W-1:0]    peer_key_q;
  logic [SEQ_W-1:0]    seq_q;
  logic                act_q;
  logic [TIME_W-1:0]   now_q;
  logic [TTL_MS_W-1:0] ttl_ms_q;
  logic [TIME_W-1:0]   expiry_q;

  // Walk and bookkeeping
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             free_found_q;
  logic             status_q;
  logic [CNT_W-1:0] cnt_q;

  // Per-entry flags in flops, cleared at once by reset or clear
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [TABLE_ENTRIES-1:0] active_q;

  // Entry payload memory
  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_data_q;
  logic   mem_we;

  // Result registers
  logic                 done_q;
  logic                 status_out_q;
  logic [OUT_CNT_W-1:0] count_out_q;

  // Combinational decode
  logic                accept;
  logic                last_idx;
  logic                key_hit;
  logic                seq_stale;
  logic                due;
  logic                free_here;
  logic                drop_announce;
  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   exp_sat;
  logic [TTL_MS_W-1:0] ttl_ms;
  logic [OUT_CNT_W-1:0] cnt_sat;

  assign accept        = start && (state_q == ST_IDLE);
  assign busy          = (state_q != ST_IDLE);
  assign last_idx      = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign key_hit       = used_q[idx_q] && (rd_data_q.key == peer_key_q);
  assign seq_stale     = (seq_q <= rd_data_q.seq);
  assign due           = used_q[idx_q] && active_q[idx_q] && (now_q >= rd_data_q.expiry);
  assign free_here     = !used_q[idx_q] && !free_found_q;
  assign drop_announce = (peer_key_i == own_key_q) || (msg_group_i != group_key_q);
  assign ttl_ms        = TTL_MS_W'(ttl_seconds_i) * TTL_MS_W'(MS_PER_SECOND);
  assign exp_sum       = {1'b0, now_q} + (TIME_W + 1)'(ttl_ms_q);
  assign exp_sat       = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
  assign cnt_sat       = (32'(cnt_q) > OUT_CNT_MAX) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                    : OUT_CNT_W'(cnt_q);
  assign mem_we        = (state_q == ST_WRITE);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_key_q   <= '0;
      group_key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_KEY:   own_key_q   <= cfg_wdata_i;
        CFG_GROUP_KEY: group_key_q <= cfg_wdata_i[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= '{key: peer_key_q, seq: seq_q, expiry: expiry_q};
    end
    rd_data_q <= mem_q[idx_q];
  end

  // Command payload latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q   <= action_i;
      peer_key_q <= peer_key_i;
      seq_q      <= seq_i;
      act_q      <= announce_active_i;
      now_q      <= now_ms_i;
      ttl_ms_q   <= ttl_ms;
    end
    if (state_q == ST_CALC) begin
      expiry_q <= exp_sat;
    end
  end

  // Sequencer, flags, count and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      slot_q       <= '0;
      free_idx_q   <= '0;
      free_found_q <= 1'b0;
      status_q     <= STATUS_OK;
      cnt_q        <= '0;
      used_q       <= '0;
      active_q     <= '0;
      done_q       <= 1'b0;
      status_out_q <= STATUS_OK;
      count_out_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          idx_q        <= '0;
          free_found_q <= 1'b0;
          status_q     <= STATUS_OK;
          if (start) begin
            case (action_i)
              ACT_ANNOUNCE: state_q <= drop_announce ? ST_FINISH : ST_CALC;
              ACT_EXPIRE:   state_q <= ST_RD;
              ACT_CLEAR: begin
                used_q   <= '0;
                active_q <= '0;
                cnt_q    <= '0;
                state_q  <= ST_FINISH;
              end
              default:      state_q <= ST_FINISH;
            endcase
          end
        end
        ST_CALC: begin
          state_q <= ST_RD;
        end
        ST_RD: begin
          // read data for idx_q arrives next cycle
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (action_q == ACT_EXPIRE) begin
            if (due) begin
              active_q[idx_q] <= 1'b0;
              cnt_q           <= cnt_q - CNT_W'(1);
            end
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= last_idx ? ST_FINISH : ST_RD;
          end else if (key_hit) begin
            // known peer: newer sequence refreshes or frees the entry
            if (seq_stale) begin
              state_q <= ST_FINISH;
            end else if (act_q) begin
              slot_q  <= idx_q;
              state_q <= ST_WRITE;
            end else begin
              used_q[idx_q]   <= 1'b0;
              active_q[idx_q] <= 1'b0;
              if (active_q[idx_q]) begin
                cnt_q <= cnt_q - CNT_W'(1);
              end
              state_q <= ST_FINISH;
            end
          end else begin
            if (free_here) begin
              free_found_q <= 1'b1;
              free_idx_q   <= idx_q;
            end
            if (last_idx) begin
              // unknown peer: take the lowest free slot
              if (!act_q) begin
                state_q <= ST_FINISH;
              end else if (free_found_q || free_here) begin
                slot_q  <= free_found_q ? free_idx_q : idx_q;
                state_q <= ST_WRITE;
              end else begin
                status_q <= STATUS_FULL;
                state_q  <= ST_FINISH;
              end
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_RD;
            end
          end
        end
        ST_WRITE: begin
          if (!(used_q[slot_q] && active_q[slot_q])) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          used_q[slot_q]   <= 1'b1;
          active_q[slot_q] <= 1'b1;
          state_q          <= ST_FINISH;
        end
        ST_FINISH: begin
          done_q       <= 1'b1;
          status_out_q <= status_q;
          count_out_q  <= cnt_sat;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_out_q;
  assign active_count_o = count_out_q;

endmodule

// ----- verif/tb_peer_table_with_expiry.sv -----
// Self-checking testbench for the peer table with expiry: directed and random command beats.
`timescale 1ns / 100ps

module tb_peer_table_with_expiry;
  import pte_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned POOL = 24;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef enum bit {BEAT_CMD, BEAT_CFG} beat_kind_e;

  // One pending beat: a command, or a register write done while the block is idle
  typedef struct {
    beat_kind_e         kind;
    logic               cfg_idx;
    logic [KEY_W-1:0]   cfg_data;
    logic [1:0]         action;
    logic [KEY_W-1:0]   key;
    logic [GRP_W-1:0]   grp;
    logic [SEQ_W-1:0]   seq;
    logic               act;
    logic [TTL_W-1:0]   ttl;
    logic [TIME_W-1:0]  now;
    int unsigned        gap;
  } peer_cmd_t;

  typedef struct {
    logic                 status;
    logic [OUT_CNT_W-1:0] count;
  } peer_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [KEY_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           action_i = '0;
  logic [KEY_W-1:0]     peer_key_i = '0;
  logic [GRP_W-1:0]     msg_group_i = '0;
  logic [SEQ_W-1:0]     seq_i = '0;
  logic                 announce_active_i = 1'b0;
  logic [TTL_W-1:0]     ttl_seconds_i = '0;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic                 done_o;
  logic                 status_o;
  logic [OUT_CNT_W-1:0] active_count_o;

  peer_table_with_expiry u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .peer_key_i        (peer_key_i),
    .msg_group_i       (msg_group_i),
    .seq_i             (seq_i),
    .announce_active_i (announce_active_i),
    .ttl_seconds_i     (ttl_seconds_i),
    .now_ms_i          (now_ms_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .active_count_o    (active_count_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  peer_cmd_t   cmd_q[$];
  peer_reply_t reply_q[$];
  peer_cmd_t   cur_cmd;
  int unsigned idle_left = 0;

  int unsigned err_cnt = 0;
  int unsigned n_checked = 0;
  int unsigned n_full = 0;
  int unsigned peak_count = 0;
  int unsigned n_announce = 0;
  int unsigned n_tick = 0;
  int unsigned n_clear = 0;
  int unsigned n_other = 0;
  int unsigned n_cfg = 0;

  // Shadow copy of the table and the registers
  logic [KEY_W-1:0]  my_key = '0;
  logic [GRP_W-1:0]  my_group = '0;
  logic              slot_used   [TABLE_ENTRIES] = '{default: 1'b0};
  logic [KEY_W-1:0]  slot_key    [TABLE_ENTRIES] = '{default: '0};
  logic [SEQ_W-1:0]  slot_seq    [TABLE_ENTRIES] = '{default: '0};
  logic              slot_active [TABLE_ENTRIES] = '{default: 1'b0};
  logic [TIME_W-1:0] slot_expiry [TABLE_ENTRIES] = '{default: '0};

  function automatic void free_slot(input int s);
    slot_used[s] = 1'b0;
    slot_key[s] = '0;
    slot_seq[s] = '0;
    slot_active[s] = 1'b0;
    slot_expiry[s] = '0;
  endfunction

  // Applies one command to the shadow table and returns the reply it must produce
  function automatic peer_reply_t update_peer_table(input peer_cmd_t c);
    peer_reply_t r;
    int slot;
    int i;
    int unsigned n;
    logic [TIME_W:0] due;
    r.status = STATUS_OK;
    slot = -1;
    case (c.action)
      ACT_ANNOUNCE: begin
        if (c.key != my_key && c.grp == my_group) begin
          for (i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && slot_used[i] && slot_key[i] == c.key) slot = i;
          // stale sequence, or a leave from a peer we never saw: no change
          if (!((slot >= 0 && c.seq <= slot_seq[slot]) || (slot < 0 && !c.act))) begin
            if (slot < 0) begin
              for (i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && !slot_used[i]) slot = i;
              if (slot < 0) begin
                r.status = STATUS_FULL;
              end else begin
                free_slot(slot);
                slot_used[slot] = 1'b1;
                slot_key[slot] = c.key;
              end
            end
            if (slot >= 0) begin
              if (c.act) begin
                slot_seq[slot] = c.seq;
                slot_active[slot] = 1'b1;
                due = {1'b0, c.now} + (TIME_W+1)'(c.ttl) * MS_PER_SECOND;
                slot_expiry[slot] = due[TIME_W] ? '1 : due[TIME_W-1:0];
              end else begin
                free_slot(slot);
              end
            end
          end
        end
      end
      ACT_EXPIRE: begin
        for (i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && slot_active[i] && c.now >= slot_expiry[i]) slot_active[i] = 1'b0;
      end
      ACT_CLEAR: begin
        for (i = 0; i < TABLE_ENTRIES; i++) free_slot(i);
      end
      default: ;
    endcase
    n = 0;
    for (i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i] && slot_active[i]) n++;
    r.count = OUT_CNT_W'((n > OUT_CNT_MAX) ? OUT_CNT_MAX : n);
    return r;
  endfunction

  task automatic push_cfg(input logic idx, input logic [KEY_W-1:0] data);
    peer_cmd_t b;
    b.kind = BEAT_CFG;
    b.cfg_idx = idx;
    b.cfg_data = data;
    b.action = ACT_ANNOUNCE;
    b.key = '0;
    b.grp = '0;
    b.seq = '0;
    b.act = 1'b0;
    b.ttl = '0;
    b.now = '0;
    b.gap = 0;
    cmd_q.push_back(b);
  endtask

  task automatic push_item(input logic [1:0] action, input logic [KEY_W-1:0] key,
                           input logic [GRP_W-1:0] grp, input logic [SEQ_W-1:0] seq,
                           input logic act, input logic [TTL_W-1:0] ttl,
                           input logic [TIME_W-1:0] now, input int unsigned gap);
    peer_cmd_t b;
    b.kind = BEAT_CMD;
    b.cfg_idx = 1'b0;
    b.cfg_data = '0;
    b.action = action;
    b.key = key;
    b.grp = grp;
    b.seq = seq;
    b.act = act;
    b.ttl = ttl;
    b.now = now;
    b.gap = gap;
    cmd_q.push_back(b);
  endtask

  // Non-announce command; the unused fields carry random bits
  task automatic push_bare(input logic [1:0] action, input logic [TIME_W-1:0] now,
                           input int unsigned gap);
    push_item(action, {$urandom, $urandom}, $urandom, $urandom, 1'($urandom),
              TTL_W'($urandom), now, gap);
  endtask

  // One configuration setting followed by mostly well-formed peer traffic
  task automatic run_phase(input logic [KEY_W-1:0] own, input logic [GRP_W-1:0] grp,
                           input logic [TIME_W-1:0] t0, input int unsigned gap_pct);
    logic [KEY_W-1:0]  pool     [POOL];
    logic [SEQ_W-1:0]  pool_seq [POOL];
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0]  key;
    logic [GRP_W-1:0]  grp_f;
    logic [SEQ_W-1:0]  seq;
    logic [TTL_W-1:0]  ttl;
    int unsigned k, n, pick, g, tsel;
    push_cfg(CFG_OWN_KEY, own);
    push_cfg(CFG_GROUP_KEY, {32'($urandom), grp});
    for (k = 0; k < POOL; k++) begin
      pool[k] = {$urandom, $urandom};
      pool_seq[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    end
    if ($urandom_range(0, 1) == 1) pool[0] = '0;
    clock_ms = t0;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      g = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 7) : 0;
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 1500);
      k = $urandom_range(0, POOL - 1);
      if (pick < 72) begin
        // join (most) or leave from a known peer, sequence mostly moving up
        key = ($urandom_range(0, 29) == 0) ? own : pool[k];
        grp_f = ($urandom_range(0, 19) == 0) ? GRP_W'($urandom) : grp;
        if ($urandom_range(0, 9) == 0) begin
          seq = pool_seq[k] - $urandom_range(0, 2);
        end else begin
          seq = pool_seq[k] + $urandom_range(1, 3);
          pool_seq[k] = seq;
        end
        tsel = $urandom_range(0, 19);
        if (tsel == 0) ttl = TTL_W'($urandom);
        else if (tsel < 12) ttl = TTL_W'($urandom_range(0, 4));
        else ttl = TTL_W'($urandom_range(30, 600));
        push_item(ACT_ANNOUNCE, key, grp_f, seq, pick < 60, ttl, clock_ms, g);
      end else if (pick < 86) begin
        push_bare(ACT_EXPIRE, clock_ms, g);
      end else if (pick < 88) begin
        push_bare(ACT_CLEAR, clock_ms, g);
      end else if (pick < 90) begin
        push_bare(ACT_UNUSED, clock_ms, g);
      end else begin
        // noise: every field random
        push_item(2'($urandom), {$urandom, $urandom}, $urandom, $urandom, 1'($urandom),
                  TTL_W'($urandom), {16'($urandom), 32'($urandom)}, g);
      end
    end
  endtask

  // Driver: presents beats from cmd_q, predicts on each accepting edge
  always @(posedge clk_i) begin : drive
    logic go;
    logic we;
    peer_cmd_t head;
    if (rst_ni) begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        reply_q.push_back(update_peer_table(cur_cmd));
        case (cur_cmd.action)
          ACT_ANNOUNCE: n_announce++;
          ACT_EXPIRE:   n_tick++;
          ACT_CLEAR:    n_clear++;
          default:      n_other++;
        endcase
        go = 1'b0;
      end
      if (!go && cmd_q.size() != 0) begin
        head = cmd_q[0];
        if (idle_left != 0) begin
          idle_left--;
        end else if (head.kind == BEAT_CFG) begin
          // register writes only once the block has drained
          if (reply_q.size() == 0 && !busy && !done_o) begin
            if (head.cfg_idx == CFG_OWN_KEY) my_key = head.cfg_data;
            else my_group = head.cfg_data[GRP_W-1:0];
            cfg_idx_i <= head.cfg_idx;
            cfg_wdata_i <= head.cfg_data;
            we = 1'b1;
            void'(cmd_q.pop_front());
            n_cfg++;
          end
        end else if (head.gap != 0) begin
          idle_left = head.gap - 1;
          cmd_q[0].gap = 0;
        end else begin
          cur_cmd = head;
          action_i <= head.action;
          peer_key_i <= head.key;
          msg_group_i <= head.grp;
          seq_i <= head.seq;
          announce_active_i <= head.act;
          ttl_seconds_i <= head.ttl;
          now_ms_i <= head.now;
          go = 1'b1;
          void'(cmd_q.pop_front());
        end
      end
      start <= go;
      cfg_we_i <= we;
    end
  end

  // Monitor: each result beat against the oldest expected reply
  always @(posedge clk_i) begin : check
    peer_reply_t want;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d count %0d",
                 $time, status_o, active_count_o);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        n_checked++;
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status_o);
          err_cnt++;
        end
        if (active_count_o !== want.count) begin
          $display("%0t: active count mismatch, expected %0d, got %0d",
                   $time, want.count, active_count_o);
          err_cnt++;
        end
        if (want.status == STATUS_FULL) n_full++;
        if (want.count > peak_count) peak_count = want.count;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned k;
    // directed: filters, saturation, full table, leave, clear, unused code
    push_cfg(CFG_OWN_KEY, '1);
    push_cfg(CFG_GROUP_KEY, 64'h0000_0000_FFFF_FFFF);
    push_item(ACT_ANNOUNCE, '0, '1, 32'd1, 1'b1, '0, '0, 0);             // key zero joins
    push_item(ACT_ANNOUNCE, '1, '1, 32'd9, 1'b1, 16'd5, 48'd10, 2);      // own key
    push_item(ACT_ANNOUNCE, 64'd7, '0, 32'd9, 1'b1, 16'd5, 48'd10, 0);   // other group
    push_item(ACT_ANNOUNCE, '0, '1, 32'd1, 1'b1, 16'd5, 48'd10, 0);      // repeated sequence
    push_item(ACT_ANNOUNCE, 64'd5, '1, 32'd3, 1'b0, 16'd5, 48'd10, 1);   // leave, unknown peer
    push_item(ACT_ANNOUNCE, '0, '1, '1, 1'b1, '1, '1, 0);                // expiry saturates
    for (k = 1; k < TABLE_ENTRIES; k++)
      push_item(ACT_ANNOUNCE, KEY_W'(k), '1, 32'd1, 1'b1, 16'd10, 48'd1000, k % 3);
    push_bare(ACT_EXPIRE, '1, 0);                                         // everything due
    push_item(ACT_ANNOUNCE, 64'd100, '1, 32'd1, 1'b1, 16'd1, 48'd5, 0);  // table full
    push_item(ACT_ANNOUNCE, 64'd3, '1, 32'd2, 1'b0, 16'd0, 48'd5, 0);    // leave frees slot
    push_item(ACT_ANNOUNCE, 64'd100, '1, 32'd1, 1'b1, 16'd1, 48'd5, 0);  // reuses it
    push_bare(ACT_CLEAR, '0, 0);
    push_bare(ACT_UNUSED, '0, 3);

    // random phases over several register settings; last one without idling
    run_phase('0, '0, '0, 30);
    run_phase('1, '1, {16'($urandom), 32'($urandom)}, 0);
    run_phase({$urandom, $urandom}, $urandom, 48'hFFFF_FFFF_FFFF - 48'd20000, 50);
    run_phase({$urandom, $urandom}, $urandom, {16'($urandom), 32'($urandom)}, 30);
    run_phase({$urandom, $urandom}, '1, '0, 40);
    run_phase({$urandom, $urandom}, $urandom, {16'($urandom), 32'($urandom)}, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // a reply still owed at the end is a lost result beat
    if (reply_q.size() != 0) begin
      $display("%0t: %0d result beats missing, expected count %0d, got none",
               $time, reply_q.size(), reply_q[0].count);
      err_cnt++;
    end

    $display("Ran %0d announces, %0d expire ticks, %0d clears, %0d other commands, %0d writes",
             n_announce, n_tick, n_clear, n_other, n_cfg);
    $display("Checked %0d replies: %0d table-full, peak active count %0d, %0d errors",
             n_checked, n_full, peak_count, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
